[hdl/three_stage_biquad_equalizer_assert.svh]
// Assertion macros for the three-section biquad equalizer.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef THREE_STAGE_BIQUAD_EQUALIZER_ASSERT_SVH
`define THREE_STAGE_BIQUAD_EQUALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSBQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tsbq_pkg.sv]
// Shared types and constants for the three-section biquad equalizer.
// No dependencies; imported by three_stage_biquad_equalizer.
`timescale 1ns / 1ps

package tsbq_pkg;

  localparam int SECTIONS  = 3;
  localparam int REG_COUNT = 2 * SECTIONS;
  localparam int SEC_W     = $clog2(SECTIONS);
  localparam int TAP_W     = 3;
  localparam int CFG_IDX_W = $clog2(REG_COUNT);

  // Multiply-accumulate step within one section.
  localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
  localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
  localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
  localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
  localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_FINAL
  } tsbq_state_t;

endpackage

[hdl/three_stage_biquad_equalizer.sv]
// Three cascaded direct-form-1 biquads (low shelf, mid peak, high shelf) on one
// shared multiplier and accumulator. Depends on tsbq_pkg and the assertion header.
//
// Usage:
//   Input beats carry one PCM sample on in_tdata, clear_history on in_tuser and
//   the buffer end mark on in_tlast. Output beats carry the equalized sample on
//   out_tdata, the saturation flag on out_tuser and the copied mark on out_tlast.
//   Coefficients are written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   Each section runs five multiplies on one multiplier, then drains the product
//   register, then rounds, saturates and shifts its history; after the last
//   section a final step rounds and saturates to the sample width. A new input
//   is taken only in the idle state, so the block does not accept a new sample
//   until the previous one has left the final step. The single multiplier sets
//   this sequential schedule.
// Reset and stall:
//   Reset clears all histories, loads b0 = 1.0 and all other coefficients 0 in
//   every section, and empties the output register. A result waits in the output
//   register while out_tready is low; the next sample may already be accepted
//   and computed, and it then waits in the final step until the register frees.
`timescale 1ns / 1ps

`include "three_stage_biquad_equalizer_assert.svh"

module three_stage_biquad_equalizer
  import tsbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEFF_WIDTH  = 20,
  parameter int GUARD_BITS   = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] in_tdata,  // [SW-1:0] sample_in
  input  logic                                   in_tuser,  // [0] clear_history
  input  logic                                   in_tlast,  // block_last
  // Output stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] out_tdata, // [SW-1:0] sample_out
  output logic                                   out_tuser, // [0] clipped
  output logic                                   out_tlast, // block_last_out
  // Coefficient write port
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [3*COEFF_WIDTH-1:0]               cfg_data
);

  localparam int DATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int HW         = SAMPLE_WIDTH + GUARD_BITS;
  localparam int COEFF_FRAC = COEFF_WIDTH - 3;
  localparam int PROD_W     = COEFF_WIDTH + HW;
  localparam int ACC_W      = PROD_W + 3;
  localparam int FIN_W      = SAMPLE_WIDTH + 1;

  localparam logic [3*COEFF_WIDTH-1:0] FF_RST =
    {{(2*COEFF_WIDTH){1'b0}}, COEFF_WIDTH'(1 << COEFF_FRAC)};
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (COEFF_FRAC - 1));
  localparam logic signed [ACC_W-1:0] HIST_MAX =
    {{(ACC_W-HW+1){1'b0}}, {(HW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] HIST_MIN =
    {{(ACC_W-HW+1){1'b1}}, {(HW-1){1'b0}}};

  // Control
  tsbq_state_t state_r, state_nxt;
  logic [SEC_W-1:0] sec_r;
  logic [TAP_W-1:0] tap_r;
  logic             out_free;
  logic             accept;
  logic             mac_issue, round_en, final_load;

  // Coefficients
  logic [3*COEFF_WIDTH-1:0] ff_r [SECTIONS];
  logic [2*COEFF_WIDTH-1:0] fb_r [SECTIONS];

  // Histories
  logic signed [HW-1:0] x1_r [SECTIONS];
  logic signed [HW-1:0] x2_r [SECTIONS];
  logic signed [HW-1:0] y1_r [SECTIONS];
  logic signed [HW-1:0] y2_r [SECTIONS];

  // Datapath
  logic signed [HW-1:0]          cur_r;
  logic                          last_r;
  logic                          clip_r;
  logic signed [COEFF_WIDTH-1:0] coef_sel;
  logic signed [HW-1:0]          op_sel;
  logic                          sub_sel;
  logic signed [PROD_W-1:0]      prod_r;
  logic                          prod_sub_r;
  logic                          prod_vld_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [HW-1:0]          y_sat;
  logic                          y_clip;
  logic signed [HW-1:0]          x0_in;
  logic signed [FIN_W-1:0]       fin;
  logic [SAMPLE_WIDTH-1:0]       fin_sat;
  logic                          fin_clip;

  // Output register
  logic                    out_tvalid_r;
  logic [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                    out_clip_r;
  logic                    out_last_r;

  assign out_free = !out_tvalid_r || out_tready;
  assign accept   = in_tvalid && in_tready;
  assign x0_in    = HW'($signed(in_tdata[SAMPLE_WIDTH-1:0])) <<< GUARD_BITS;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MAC;
      ST_MAC:   if (tap_r == TAP_A2) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = (sec_r == SEC_W'(SECTIONS - 1)) ? ST_FINAL : ST_MAC;
      ST_FINAL: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer
  always_comb begin
    in_tready  = 1'b0;
    mac_issue  = 1'b0;
    round_en   = 1'b0;
    final_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready  = rst_n;
      ST_MAC:   mac_issue  = 1'b1;
      ST_DRAIN: ;
      ST_ROUND: round_en   = 1'b1;
      ST_FINAL: final_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    coef_sel = ff_r[sec_r][0 +: COEFF_WIDTH];
    op_sel   = cur_r;
    sub_sel  = 1'b0;
    unique case (tap_r)
      TAP_B0: begin
        coef_sel = ff_r[sec_r][0 +: COEFF_WIDTH];
        op_sel   = cur_r;
      end
      TAP_B1: begin
        coef_sel = ff_r[sec_r][COEFF_WIDTH +: COEFF_WIDTH];
        op_sel   = x1_r[sec_r];
      end
      TAP_B2: begin
        coef_sel = ff_r[sec_r][2*COEFF_WIDTH +: COEFF_WIDTH];
        op_sel   = x2_r[sec_r];
      end
      TAP_A1: begin
        coef_sel = fb_r[sec_r][0 +: COEFF_WIDTH];
        op_sel   = y1_r[sec_r];
        sub_sel  = 1'b1;
      end
      TAP_A2: begin
        coef_sel = fb_r[sec_r][COEFF_WIDTH +: COEFF_WIDTH];
        op_sel   = y2_r[sec_r];
        sub_sel  = 1'b1;
      end
      default: ;
    endcase
  end

  // Section result: round half up, then saturate to the history width.
  assign rnd    = (acc_r + ACC_HALF) >>> COEFF_FRAC;
  always_comb begin
    y_clip = 1'b0;
    y_sat  = rnd[HW-1:0];
    if (rnd > HIST_MAX) begin
      y_clip = 1'b1;
      y_sat  = HIST_MAX[HW-1:0];
    end else if (rnd < HIST_MIN) begin
      y_clip = 1'b1;
      y_sat  = HIST_MIN[HW-1:0];
    end
  end

  // Final rounding to the sample width.
  generate
    if (GUARD_BITS > 0) begin : g_fin_round
      logic signed [HW:0] fin_sum;
      assign fin_sum = $signed({cur_r[HW-1], cur_r}) + (HW + 1)'(1 << (GUARD_BITS - 1));
      assign fin     = FIN_W'(fin_sum >>> GUARD_BITS);
    end else begin : g_fin_pass
      assign fin = FIN_W'(cur_r);
    end
  endgenerate

  always_comb begin
    fin_clip = fin[FIN_W-1] != fin[FIN_W-2];
    fin_sat  = fin[SAMPLE_WIDTH-1:0];
    if (fin_clip) fin_sat = {fin[FIN_W-1], {(SAMPLE_WIDTH-1){!fin[FIN_W-1]}}};
  end

  // Sequencer counters and the product pipeline register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r      <= '0;
      tap_r      <= TAP_B0;
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= mac_issue;
      if (accept) begin
        sec_r <= '0;
        tap_r <= TAP_B0;
      end else if (mac_issue) begin
        tap_r <= (tap_r == TAP_A2) ? TAP_B0 : tap_r + TAP_W'(1);
      end else if (round_en) begin
        sec_r <= (sec_r == SEC_W'(SECTIONS - 1)) ? '0 : sec_r + SEC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_issue) begin
      prod_r     <= coef_sel * op_sel;
      prod_sub_r <= sub_sel;
    end
    if (mac_issue && tap_r == TAP_B0) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= prod_sub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    if (accept) begin
      cur_r  <= x0_in;
      last_r <= in_tlast;
    end else if (round_en) begin
      cur_r <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
    end else if (accept) begin
      clip_r <= 1'b0;
    end else if (round_en) begin
      clip_r <= clip_r | y_clip;
    end
  end

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS; i++) begin
        ff_r[i] <= FF_RST;
        fb_r[i] <= '0;
      end
    end else if (cfg_we && cfg_index < CFG_IDX_W'(REG_COUNT)) begin
      if (cfg_index[0]) fb_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data[2*COEFF_WIDTH-1:0];
      else              ff_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
    end
  end

  // Histories: a clear request zeroes every section before the sample runs.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_tuser)) begin
      for (int i = 0; i < SECTIONS; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (round_en) begin
      x2_r[sec_r] <= x1_r[sec_r];
      x1_r[sec_r] <= cur_r;
      y2_r[sec_r] <= y1_r[sec_r];
      y1_r[sec_r] <= y_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (final_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (final_load) begin
      out_sample_r <= fin_sat;
      out_clip_r   <= clip_r | fin_clip;
      out_last_r   <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'(out_sample_r);
  assign out_tuser  = out_clip_r;
  assign out_tlast  = out_last_r;

  `TSBQ_ASSERT_NEXT(a_accept_starts_mac, accept,
    state_r == ST_MAC && tap_r == TAP_B0 && sec_r == '0,
    "accepted sample did not start at the first tap of the first section")
  `TSBQ_ASSERT_SAME(a_tap_range, state_r == ST_MAC, tap_r <= TAP_A2,
    "tap counter ran past the last tap")
  `TSBQ_ASSERT_SAME(a_sec_range, 1'b1, sec_r < SEC_W'(SECTIONS),
    "section counter ran past the last section")
  `TSBQ_ASSERT_SAME(a_idle_pipe_empty, in_tready, !prod_vld_r,
    "product register still busy while accepting a new sample")
  `TSBQ_ASSERT_NEXT(a_final_loads_out, final_load, out_tvalid_r,
    "final step did not load the output register")

endmodule
